// ----- rtl/core/sps_pkg.sv -----
package sps_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int SCORE_W     = 16;
    localparam int CNT_W       = 10;
    localparam int BASES       = 4;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int PTR_W       = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W       = (PTR_W > CNT_W) ? PTR_W : CNT_W;
    localparam int ACC_W       = SCORE_W + 2;

    localparam logic [SCORE_W-1:0] LEAF_MISMATCH = SCORE_W'(2);
    localparam logic [ACC_W-1:0]   SCORE_MAX     = ACC_W'((64'd1 << SCORE_W) - 64'd1);

    typedef logic [BASES-1:0][SCORE_W-1:0] score_vec_t;

    typedef struct packed {
        logic             is_leaf;
        logic [3:0]       leaf_base;
        logic [CNT_W-1:0] child_count;
        logic             pass_end;
    } sps_in_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score_a;
        logic [SCORE_W-1:0] score_c;
        logic [SCORE_W-1:0] score_g;
        logic [SCORE_W-1:0] score_t;
        logic [SCORE_W-1:0] best_score;
        logic [BASES-1:0]   best_set;
        logic               error;
    } sps_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_PUSH,
        ST_EMIT
    } sps_state_t;

    typedef struct packed {
        logic s_ready;
        logic rd_en;
        logic wr_en;
        logic ms_in_valid;
        logic emit_load;
    } sps_ctrl_t;

endpackage

// ----- rtl/core/sps_ram.sv -----
module sps_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end
            rdata <= mem[addr];
        end
    end

endmodule

// ----- rtl/core/sps_minset.sv -----
module sps_minset (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    input  sps_pkg::score_vec_t          in_vec,
    output logic                         out_valid,
    output logic [sps_pkg::SCORE_W-1:0]  out_min,
    output logic [sps_pkg::BASES-1:0]    out_set
);
    import sps_pkg::*;

    logic [SCORE_W-1:0] min01;
    logic [SCORE_W-1:0] min23;
    logic [SCORE_W-1:0] min_all;
    logic [BASES-1:0]   set_all;
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_min_reg;
    logic [BASES-1:0]   out_set_reg;

    always_comb begin
        min01   = (in_vec[1] < in_vec[0]) ? in_vec[1] : in_vec[0];
        min23   = (in_vec[3] < in_vec[2]) ? in_vec[3] : in_vec[2];
        min_all = (min23 < min01) ? min23 : min01;
        for (int i = 0; i < BASES; i++) begin
            set_all[i] = (in_vec[i] == min_all);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid) begin
            out_min_reg <= min_all;
            out_set_reg <= set_all;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_min   = out_min_reg;
    assign out_set   = out_set_reg;

endmodule

// ----- rtl/core/sankoff_parsimony_scorer_core.sv -----
// Bottom-up Sankoff parsimony scorer for one site over A, C, G, T with unit
// cost. Nodes arrive in reverse pre-order on s_payload; each one yields one
// result on m_payload. Child score vectors live in a single-port stack RAM,
// and one shared min/tie-set unit serves both the popped children and the
// final vector. A leaf or a node without children passes through push and
// emit, an internal node first pops each child vector with one RAM read per
// child into the min/set unit, and a rejected node goes straight to emit.
// A result may wait in the output register while the next node is accepted.
// The stack needs no clearing pass after reset.
module sankoff_parsimony_scorer_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sps_pkg::sps_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output sps_pkg::sps_out_t m_payload
);
    import sps_pkg::*;

    sps_state_t        state_reg;
    sps_state_t        state_next;
    sps_ctrl_t         ctrl;

    logic [PTR_W-1:0]  sp_reg;
    logic [PTR_W-1:0]  sp_base_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  acc_cnt_reg;
    logic              dout_vld_reg;
    logic              err_reg;
    logic              pass_end_reg;
    logic              m_valid_reg;
    sps_out_t          m_payload_reg;
    score_vec_t        acc_reg;

    logic              accept;
    logic              base_onehot;
    logic [CMP_W-1:0]  count_ext;
    logic [CMP_W-1:0]  sp_ext;
    logic [CMP_W-1:0]  sp_base_cmp;
    logic              item_err;
    score_vec_t        leaf_vec;
    score_vec_t        acc_next;
    logic              pop_done;

    logic [ADDR_W-1:0] ram_addr;
    score_vec_t        ram_rdata;
    score_vec_t        ms_in_vec;
    logic              ms_valid;
    logic [SCORE_W-1:0] ms_min;
    logic [BASES-1:0]  ms_set;

    assign accept      = s_valid && ctrl.s_ready;
    assign base_onehot = (s_payload.leaf_base != 4'd0)
                      && ((s_payload.leaf_base & (s_payload.leaf_base - 4'd1)) == 4'd0);
    assign count_ext   = CMP_W'(s_payload.child_count);
    assign sp_ext      = CMP_W'(sp_reg);
    assign sp_base_cmp = sp_ext - count_ext;

    always_comb begin
        if (s_payload.is_leaf) begin
            item_err = !base_onehot || (sp_reg >= PTR_W'(STACK_DEPTH));
        end else begin
            item_err = (count_ext > sp_ext) || (sp_base_cmp >= CMP_W'(STACK_DEPTH));
        end
        for (int i = 0; i < BASES; i++) begin
            leaf_vec[i] = s_payload.leaf_base[i] ? '0 : LEAF_MISMATCH;
        end
    end

    always_comb begin
        logic [ACC_W-1:0] sum;
        for (int i = 0; i < BASES; i++) begin
            sum = ACC_W'(acc_reg[i]) + ACC_W'(ms_min) + ACC_W'(!ms_set[i]);
            acc_next[i] = (sum > SCORE_MAX) ? SCORE_MAX[SCORE_W-1:0] : sum[SCORE_W-1:0];
        end
    end

    assign pop_done = (state_reg == ST_POP) && ms_valid && (acc_cnt_reg == CNT_W'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (item_err) begin
                        state_next = ST_EMIT;
                    end else if (s_payload.is_leaf || (s_payload.child_count == '0)) begin
                        state_next = ST_PUSH;
                    end else begin
                        state_next = ST_POP;
                    end
                end
            end
            ST_POP: begin
                if (pop_done) begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (ctrl.emit_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ctrl.s_ready = 1'b1;
            end
            ST_POP: begin
                ctrl.rd_en       = (issue_cnt_reg != '0);
                ctrl.ms_in_valid = dout_vld_reg;
            end
            ST_PUSH: begin
                ctrl.wr_en       = 1'b1;
                ctrl.ms_in_valid = 1'b1;
            end
            ST_EMIT: begin
                ctrl.emit_load = !m_valid_reg || m_ready;
            end
            default: begin
                ctrl = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            issue_cnt_reg <= '0;
            acc_cnt_reg   <= '0;
            dout_vld_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            dout_vld_reg <= ctrl.rd_en;
            if (accept) begin
                issue_cnt_reg <= item_err ? '0 : s_payload.child_count;
                acc_cnt_reg   <= item_err ? '0 : s_payload.child_count;
            end else begin
                if (ctrl.rd_en) begin
                    issue_cnt_reg <= issue_cnt_reg - CNT_W'(1);
                end
                if ((state_reg == ST_POP) && ms_valid) begin
                    acc_cnt_reg <= acc_cnt_reg - CNT_W'(1);
                end
            end
            if (ctrl.emit_load) begin
                m_valid_reg <= 1'b1;
                if (pass_end_reg) begin
                    sp_reg <= '0;
                end else if (!err_reg) begin
                    sp_reg <= sp_base_reg + PTR_W'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            err_reg      <= item_err;
            pass_end_reg <= s_payload.pass_end;
            rd_ptr_reg   <= sp_reg - PTR_W'(1);
            sp_base_reg  <= s_payload.is_leaf ? sp_reg : PTR_W'(sp_base_cmp);
            acc_reg      <= s_payload.is_leaf ? leaf_vec : '0;
        end else begin
            if (ctrl.rd_en) begin
                rd_ptr_reg <= rd_ptr_reg - PTR_W'(1);
            end
            if ((state_reg == ST_POP) && ms_valid) begin
                acc_reg <= acc_next;
            end
        end
        if (ctrl.emit_load) begin
            if (err_reg) begin
                m_payload_reg       <= '0;
                m_payload_reg.error <= 1'b1;
            end else begin
                m_payload_reg.score_a    <= acc_reg[0];
                m_payload_reg.score_c    <= acc_reg[1];
                m_payload_reg.score_g    <= acc_reg[2];
                m_payload_reg.score_t    <= acc_reg[3];
                m_payload_reg.best_score <= ms_min;
                m_payload_reg.best_set   <= ms_set;
                m_payload_reg.error      <= 1'b0;
            end
        end
    end

    assign ram_addr  = ctrl.wr_en ? sp_base_reg[ADDR_W-1:0] : rd_ptr_reg[ADDR_W-1:0];
    assign ms_in_vec = (state_reg == ST_PUSH) ? acc_reg : ram_rdata;

    sps_ram #(
        .WIDTH($bits(score_vec_t)),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .en    (ctrl.rd_en || ctrl.wr_en),
        .we    (ctrl.wr_en),
        .addr  (ram_addr),
        .wdata (acc_reg),
        .rdata (ram_rdata)
    );

    sps_minset u_minset (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ctrl.ms_in_valid),
        .in_vec    (ms_in_vec),
        .out_valid (ms_valid),
        .out_min   (ms_min),
        .out_set   (ms_set)
    );

    assign s_ready   = ctrl.s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

`ifndef SYNTH
    a_sp_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sp_reg <= PTR_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_push_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.wr_en |-> (sp_base_reg < PTR_W'(STACK_DEPTH)))
        else $error("push beyond stack depth");

    a_read_below_sp: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.rd_en |-> (rd_ptr_reg < sp_reg) && (rd_ptr_reg >= sp_base_reg))
        else $error("pop outside the live stack");

    a_acc_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_POP) && ms_valid) |-> (acc_cnt_reg != '0))
        else $error("child vector without pending count");

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.emit_load |=> m_valid && (state_reg == ST_IDLE))
        else $error("result not presented after load");
`endif

endmodule
